FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// hold prop at every clock edge outside reset
`define FCLB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// flag expr whenever it goes true outside reset
`define FCLB_NEVER(lbl, expr, msg) \
  `FCLB_ASSERT(lbl, !(expr), msg)

`endif

FILE: sv/fclb_pkg.sv
// ----------------------------------------------------------------------------
// fclb_pkg
// Types and constants of the circulation-with-lower-bounds solver.
// ----------------------------------------------------------------------------
`default_nettype none

package fclb_pkg;

  localparam int unsigned NODE_W        = 6;
  localparam int unsigned BOUND_W       = 20;
  localparam int unsigned IDX_W         = 6;
  localparam int unsigned ARCS_PER_EDGE = 6;
  localparam int unsigned STACK_DEPTH   = 64;
  localparam int unsigned SAW           = 6;

  localparam int unsigned DEF_MAX_NODES = 62;
  localparam int unsigned DEF_MAX_EDGES = 64;
  localparam int unsigned DEF_CAP_BITS  = 20;

  localparam logic [NODE_W-1:0] NODE_COUNT_RST = 6'd62;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOCIRC = 2'd1,
    ST_BAD    = 2'd2
  } status_e;

  typedef enum logic [5:0] {
    S_IDLE, S_LD_RD, S_LD_WR, S_RUN,
    S_BF_START, S_BF_POP, S_BF_POPW, S_BF_LIST, S_BF_ARC, S_BF_ARCW,
    S_DF_INIT, S_DF_PATH, S_DF_NODE, S_DF_CUR, S_DF_SCAN, S_DF_SCANW, S_DF_LVLW,
    S_DF_RET, S_DF_RETW, S_DF_RETC, S_DF_RETN,
    S_PU_RD, S_PU_W, S_PU_A, S_PU_B,
    S_CK_RD, S_CK_W, S_CK_DONE,
    S_EM_ST, S_OUT_A, S_OUT_B, S_OUT_C, S_CLEAR
  } state_e;

  typedef struct packed {
    logic                 valid;
    status_e              status;
    logic [IDX_W-1:0]     idx;
    logic [BOUND_W-1:0]   flow;
    logic                 last;
  } res_t;

endpackage

`default_nettype wire

FILE: sv/fclb_ram.sv
// ----------------------------------------------------------------------------
// fclb_ram
// Generic memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module fclb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

FILE: sv/fclb_obuf.sv
// ----------------------------------------------------------------------------
// fclb_obuf
// Output register stage between the solver and the result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module fclb_obuf (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  fclb_pkg::res_t     res_i,
  output logic               res_ready_o,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  output logic [31:0]        m_axis_tdata,   // edge_index[5:0], edge_flow[25:6]
  output logic [1:0]         m_axis_tuser,   // status[1:0]
  output logic               m_axis_tlast
);
  import fclb_pkg::*;

  logic full_q;
  res_t word_q;

  assign res_ready_o = !full_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else if (res_i.valid && res_ready_o) begin
      full_q <= 1'b1;
    end else if (m_axis_tready) begin
      full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_i.valid && res_ready_o) begin
      word_q <= res_i;
    end
  end

  assign m_axis_tvalid = full_q;
  assign m_axis_tdata  = {6'd0, word_q.flow, word_q.idx};
  assign m_axis_tuser  = word_q.status;
  assign m_axis_tlast  = word_q.last;

endmodule

`default_nettype wire

FILE: sv/fclb_engine.sv
// ----------------------------------------------------------------------------
// fclb_engine
// Edge loader and level / blocking-flow sequencer over the arc and vertex
// memories.
// ----------------------------------------------------------------------------
`default_nettype none

module fclb_engine #(
  parameter int unsigned MAX_NODES = fclb_pkg::DEF_MAX_NODES,
  parameter int unsigned MAX_EDGES = fclb_pkg::DEF_MAX_EDGES,
  parameter int unsigned CAP_BITS  = fclb_pkg::DEF_CAP_BITS
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic [fclb_pkg::NODE_W-1:0]    node_count_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [fclb_pkg::NODE_W-1:0]    node_from_i,
  input  wire logic [fclb_pkg::NODE_W-1:0]    node_to_i,
  input  wire logic [fclb_pkg::BOUND_W-1:0]   lower_bound_i,
  input  wire logic [fclb_pkg::BOUND_W-1:0]   upper_bound_i,
  input  wire logic                           last_edge_i,
  output fclb_pkg::res_t                      res_o,
  input  wire logic                           res_ready_i
);
  import fclb_pkg::*;

  localparam int unsigned NVERT = MAX_NODES + 2;
  localparam int unsigned VW    = $clog2(NVERT);
  localparam int unsigned NARCS = MAX_EDGES * ARCS_PER_EDGE;
  localparam int unsigned AW    = $clog2(NARCS);
  localparam int unsigned NW    = AW + 1;
  localparam int unsigned EW    = $clog2(MAX_EDGES + 1);
  localparam int unsigned FW    = CAP_BITS + 2;
  localparam int unsigned LVW   = $clog2(NVERT) + 1;
  localparam int unsigned HW    = $clog2(NVERT + 1);
  localparam int unsigned WD    = (NVERT > STACK_DEPTH) ? NVERT : STACK_DEPTH;
  localparam int unsigned WAW   = $clog2(WD);
  localparam int unsigned ADW   = VW + CAP_BITS + FW;
  localparam int unsigned WKW   = AW + FW + VW;

  localparam logic [NW-1:0] ARC_NONE = {NW{1'b1}};
  localparam logic [NW-1:0] NARCS_N  = NW'(NARCS);
  localparam logic [VW-1:0] SOURCE   = '0;
  localparam logic [VW-1:0] SINK     = VW'(MAX_NODES + 1);
  localparam logic signed [FW-1:0] FLOW_INF = {1'b0, {(FW-1){1'b1}}};

  state_e state_q, state_d;

  // latched edge
  logic [VW-1:0]        ea_q, eb_q;
  logic [CAP_BITS-1:0]  elo_q, eup_q;
  logic                 elast_q;
  logic [2:0]           k_q;
  logic [AW-1:0]        base_q;
  logic [EW-1:0]        ecnt_q;
  logic                 bad_q;

  logic [NVERT-1:0]     vvld_q, reached_q, cinit_q;
  logic [VW-1:0]        rv_q, rc_q;
  logic [HW-1:0]        head_q, tail_q;
  logic [LVW-1:0]       clvl_q;
  logic [NW-1:0]        a_q, nxt_q;
  logic [SAW-1:0]       d_q, i_q;
  logic [VW-1:0]        u_q, tgt_q;
  logic signed [FW-1:0] lim_q, room_q, f_q;
  logic [AW-1:0]        pa_q, p_q;
  logic [EW-1:0]        e_q;
  logic                 infeas_q;
  status_e              code_q;

  // memory ports
  logic             ad_we;  logic [AW-1:0]  ad_waddr, ad_raddr;
  logic [ADW-1:0]   ad_wdata, ad_rdata;
  logic             nx_we;  logic [AW-1:0]  nx_waddr, nx_raddr;
  logic [NW-1:0]    nx_wdata, nx_rdata;
  logic             vl_we;  logic [VW-1:0]  vl_waddr, vl_raddr;
  logic [2*NW-1:0]  vl_wdata, vl_rdata;
  logic             lv_we;  logic [VW-1:0]  lv_waddr, lv_raddr;
  logic [LVW-1:0]   lv_wdata, lv_rdata;
  logic             cu_we;  logic [VW-1:0]  cu_waddr, cu_raddr;
  logic [NW-1:0]    cu_wdata, cu_rdata;
  logic             wk_we;  logic [WAW-1:0] wk_waddr, wk_raddr;
  logic [WKW-1:0]   wk_wdata, wk_rdata;

  fclb_ram #(.WIDTH(ADW), .DEPTH(NARCS)) u_arc (
    .clk_i, .we_i(ad_we), .waddr_i(ad_waddr), .wdata_i(ad_wdata),
    .raddr_i(ad_raddr), .rdata_o(ad_rdata));
  fclb_ram #(.WIDTH(NW), .DEPTH(NARCS)) u_next (
    .clk_i, .we_i(nx_we), .waddr_i(nx_waddr), .wdata_i(nx_wdata),
    .raddr_i(nx_raddr), .rdata_o(nx_rdata));
  fclb_ram #(.WIDTH(2*NW), .DEPTH(NVERT)) u_vlist (
    .clk_i, .we_i(vl_we), .waddr_i(vl_waddr), .wdata_i(vl_wdata),
    .raddr_i(vl_raddr), .rdata_o(vl_rdata));
  fclb_ram #(.WIDTH(LVW), .DEPTH(NVERT)) u_level (
    .clk_i, .we_i(lv_we), .waddr_i(lv_waddr), .wdata_i(lv_wdata),
    .raddr_i(lv_raddr), .rdata_o(lv_rdata));
  fclb_ram #(.WIDTH(NW), .DEPTH(NVERT)) u_cur (
    .clk_i, .we_i(cu_we), .waddr_i(cu_waddr), .wdata_i(cu_wdata),
    .raddr_i(cu_raddr), .rdata_o(cu_rdata));
  fclb_ram #(.WIDTH(WKW), .DEPTH(WD)) u_work (
    .clk_i, .we_i(wk_we), .waddr_i(wk_waddr), .wdata_i(wk_wdata),
    .raddr_i(wk_raddr), .rdata_o(wk_rdata));

  // field views
  logic [VW-1:0]        ad_tgt;
  logic [CAP_BITS-1:0]  ad_cap;
  logic signed [FW-1:0] ad_flow, cap_ext;
  logic [NW-1:0]        vfirst, vlast, cstart;
  logic [VW-1:0]        wk_node;
  logic signed [FW-1:0] wk_lim;
  logic [AW-1:0]        wk_arc;

  assign ad_flow = ad_rdata[FW-1:0];
  assign ad_cap  = ad_rdata[FW +: CAP_BITS];
  assign ad_tgt  = ad_rdata[FW+CAP_BITS +: VW];
  assign cap_ext = {2'b00, ad_cap};
  assign vfirst  = vvld_q[rv_q] ? vl_rdata[NW +: NW] : ARC_NONE;
  assign vlast   = vvld_q[rv_q] ? vl_rdata[NW-1:0]   : ARC_NONE;
  assign cstart  = cinit_q[rc_q] ? cu_rdata : vfirst;
  assign wk_node = wk_rdata[VW-1:0];
  assign wk_lim  = wk_rdata[VW +: FW];
  assign wk_arc  = wk_rdata[VW+FW +: AW];

  // input check
  logic [8:0] nmax, na9, nb9;
  logic       in_bad;
  assign nmax = (9'(node_count_i) > 9'(MAX_NODES)) ? 9'(MAX_NODES) : 9'(node_count_i);
  assign na9  = 9'(node_from_i);
  assign nb9  = 9'(node_to_i);
  assign in_bad = (lower_bound_i > upper_bound_i) ||
                  ((32'(lower_bound_i) >> CAP_BITS) != 0) ||
                  ((32'(upper_bound_i) >> CAP_BITS) != 0) ||
                  (na9 == 9'd0) || (nb9 == 9'd0) || (na9 > nmax) || (nb9 > nmax) ||
                  (ecnt_q >= EW'(MAX_EDGES));

  // arc k of the current edge
  logic [VW-1:0]       ld_v, ld_t;
  logic [CAP_BITS-1:0] ld_cap;
  logic [AW-1:0]       ld_arc;
  assign ld_arc = base_q + AW'(k_q);
  always_comb begin
    ld_v = eb_q; ld_t = ea_q; ld_cap = eup_q - elo_q;
    case (k_q)
      3'd0: begin ld_v = eb_q;   ld_t = ea_q;   ld_cap = eup_q - elo_q; end
      3'd1: begin ld_v = ea_q;   ld_t = eb_q;   ld_cap = '0;            end
      3'd2: begin ld_v = SOURCE; ld_t = ea_q;   ld_cap = elo_q;         end
      3'd3: begin ld_v = ea_q;   ld_t = SOURCE; ld_cap = '0;            end
      3'd4: begin ld_v = eb_q;   ld_t = SINK;   ld_cap = elo_q;         end
      3'd5: begin ld_v = SINK;   ld_t = eb_q;   ld_cap = '0;            end
      default: begin ld_v = eb_q; ld_t = ea_q;  ld_cap = '0;            end
    endcase
  end

  logic bf_take, df_ok, lv_match, stack_room;
  logic signed [FW:0] out_sum;
  logic signed [FW-1:0] room_now;
  assign bf_take = (32'(ad_tgt) < NVERT) && !reached_q[ad_tgt] && (ad_flow < cap_ext);
  assign df_ok   = (32'(ad_tgt) < NVERT) && reached_q[ad_tgt];
  assign lv_match = (lv_rdata == clvl_q + LVW'(1));
  assign stack_room = (32'(d_q) + 1) < STACK_DEPTH;
  assign room_now = cap_ext - ad_flow;
  assign out_sum = {f_q[FW-1], f_q} + {1'b0, cap_ext};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:     if (in_valid_i) begin
                    state_d = in_bad ? (last_edge_i ? S_RUN : S_IDLE) : S_LD_RD;
                  end
      S_LD_RD:    state_d = S_LD_WR;
      S_LD_WR:    if (k_q == 3'd5) begin
                    state_d = elast_q ? S_RUN : S_IDLE;
                  end else begin
                    state_d = S_LD_RD;
                  end
      S_RUN:      state_d = bad_q ? S_EM_ST : S_BF_START;
      S_BF_START: state_d = S_BF_POP;
      S_BF_POP:   if (head_q == tail_q) begin
                    state_d = reached_q[SINK] ? S_DF_INIT : S_CK_RD;
                  end else begin
                    state_d = S_BF_POPW;
                  end
      S_BF_POPW:  state_d = S_BF_LIST;
      S_BF_LIST:  state_d = S_BF_ARC;
      S_BF_ARC:   state_d = (a_q >= NARCS_N) ? S_BF_POP : S_BF_ARCW;
      S_BF_ARCW:  state_d = S_BF_ARC;
      S_DF_INIT:  state_d = S_DF_PATH;
      S_DF_PATH:  state_d = S_DF_NODE;
      S_DF_NODE:  if (lim_q == '0) begin
                    state_d = S_DF_RET;
                  end else if (u_q == SINK) begin
                    state_d = S_PU_RD;
                  end else begin
                    state_d = S_DF_CUR;
                  end
      S_DF_CUR:   state_d = S_DF_SCAN;
      S_DF_SCAN:  state_d = (a_q >= NARCS_N) ? S_DF_RET : S_DF_SCANW;
      S_DF_SCANW: state_d = df_ok ? S_DF_LVLW : S_DF_SCAN;
      S_DF_LVLW:  if (lv_match) begin
                    state_d = stack_room ? S_DF_NODE : S_DF_RET;
                  end else begin
                    state_d = S_DF_SCAN;
                  end
      S_DF_RET:   state_d = (d_q == '0) ? S_BF_START : S_DF_RETW;
      S_DF_RETW:  state_d = S_DF_RETC;
      S_DF_RETC:  state_d = (cstart >= NARCS_N) ? S_DF_NODE : S_DF_RETN;
      S_DF_RETN:  state_d = S_DF_NODE;
      S_PU_RD:    state_d = (i_q == d_q) ? S_DF_PATH : S_PU_W;
      S_PU_W:     state_d = S_PU_A;
      S_PU_A:     state_d = S_PU_B;
      S_PU_B:     state_d = S_PU_RD;
      S_CK_RD:    state_d = (e_q == ecnt_q) ? S_CK_DONE : S_CK_W;
      S_CK_W:     state_d = S_CK_RD;
      S_CK_DONE:  state_d = (infeas_q || ecnt_q == '0) ? S_EM_ST : S_OUT_A;
      S_EM_ST:    if (res_ready_i) begin
                    state_d = S_CLEAR;
                  end
      S_OUT_A:    state_d = S_OUT_B;
      S_OUT_B:    state_d = S_OUT_C;
      S_OUT_C:    if (res_ready_i) begin
                    state_d = (e_q + EW'(1) == ecnt_q) ? S_CLEAR : S_OUT_A;
                  end
      S_CLEAR:    state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // outputs and memory ports
  always_comb begin
    in_ready_o = 1'b0;
    res_o      = '0;
    ad_we = 1'b0; ad_waddr = '0; ad_wdata = '0; ad_raddr = '0;
    nx_we = 1'b0; nx_waddr = '0; nx_wdata = '0; nx_raddr = '0;
    vl_we = 1'b0; vl_waddr = '0; vl_wdata = '0; vl_raddr = '0;
    lv_we = 1'b0; lv_waddr = '0; lv_wdata = '0; lv_raddr = '0;
    cu_we = 1'b0; cu_waddr = '0; cu_wdata = '0; cu_raddr = '0;
    wk_we = 1'b0; wk_waddr = '0; wk_wdata = '0; wk_raddr = '0;
    case (state_q)
      S_IDLE: in_ready_o = 1'b1;
      S_LD_RD: begin
        vl_raddr = ld_v;
        nx_we = 1'b1; nx_waddr = ld_arc; nx_wdata = ARC_NONE;
      end
      S_LD_WR: begin
        vl_we = 1'b1; vl_waddr = ld_v;
        if (vfirst == ARC_NONE) begin
          vl_wdata = {NW'(ld_arc), NW'(ld_arc)};
        end else begin
          vl_wdata = {vfirst, NW'(ld_arc)};
          nx_we = 1'b1; nx_waddr = vlast[AW-1:0]; nx_wdata = NW'(ld_arc);
        end
        ad_we = 1'b1; ad_waddr = ld_arc; ad_wdata = {ld_t, ld_cap, FW'(0)};
      end
      S_BF_START: begin
        lv_we = 1'b1; lv_waddr = SOURCE; lv_wdata = '0;
        wk_we = 1'b1; wk_waddr = '0; wk_wdata = WKW'(SOURCE);
      end
      S_BF_POP:  wk_raddr = WAW'(head_q);
      S_BF_POPW: begin
        vl_raddr = wk_node; lv_raddr = wk_node;
      end
      S_BF_ARC: begin
        ad_raddr = a_q[AW-1:0]; nx_raddr = a_q[AW-1:0];
      end
      S_BF_ARCW: if (bf_take) begin
        lv_we = 1'b1; lv_waddr = ad_tgt; lv_wdata = clvl_q + LVW'(1);
        if (32'(tail_q) < NVERT) begin
          wk_we = 1'b1; wk_waddr = WAW'(tail_q); wk_wdata = WKW'(ad_tgt);
        end
      end
      S_DF_NODE: begin
        vl_raddr = u_q; cu_raddr = u_q; lv_raddr = u_q;
      end
      S_DF_SCAN: if (a_q >= NARCS_N) begin
        cu_we = 1'b1; cu_waddr = u_q; cu_wdata = ARC_NONE;
      end else begin
        ad_raddr = a_q[AW-1:0]; nx_raddr = a_q[AW-1:0];
      end
      S_DF_SCANW: lv_raddr = ad_tgt;
      S_DF_LVLW: if (lv_match) begin
        cu_we = 1'b1; cu_waddr = u_q; cu_wdata = a_q;
        if (stack_room) begin
          wk_we = 1'b1; wk_waddr = WAW'(d_q); wk_wdata = {a_q[AW-1:0], lim_q, u_q};
        end
      end
      S_DF_RET:  wk_raddr = WAW'(d_q - SAW'(1));
      S_DF_RETW: begin
        vl_raddr = wk_node; cu_raddr = wk_node;
      end
      S_DF_RETC: if (cstart >= NARCS_N) begin
        cu_we = 1'b1; cu_waddr = u_q; cu_wdata = ARC_NONE;
      end else begin
        nx_raddr = cstart[AW-1:0];
      end
      S_DF_RETN: begin
        cu_we = 1'b1; cu_waddr = u_q; cu_wdata = nx_rdata;
      end
      S_PU_RD: wk_raddr = WAW'(i_q);
      S_PU_W:  ad_raddr = wk_arc;
      S_PU_A: begin
        ad_we = 1'b1; ad_waddr = pa_q; ad_wdata = {ad_tgt, ad_cap, ad_flow + lim_q};
        ad_raddr = pa_q ^ AW'(1);
      end
      S_PU_B: begin
        ad_we = 1'b1; ad_waddr = pa_q ^ AW'(1);
        ad_wdata = {ad_tgt, ad_cap, ad_flow - lim_q};
      end
      S_CK_RD: ad_raddr = p_q;
      S_EM_ST: begin
        res_o.valid = 1'b1; res_o.status = code_q; res_o.last = 1'b1;
      end
      S_OUT_A: ad_raddr = p_q;
      S_OUT_B: ad_raddr = p_q + AW'(2);
      S_OUT_C: begin
        ad_raddr     = p_q + AW'(2);
        res_o.valid  = 1'b1;
        res_o.status = ST_OK;
        res_o.idx    = IDX_W'(e_q);
        res_o.flow   = out_sum[FW] ? '0 : BOUND_W'(out_sum[FW-1:0]);
        res_o.last   = (e_q + EW'(1) == ecnt_q);
      end
      default: in_ready_o = 1'b0;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ecnt_q  <= '0;
      bad_q   <= 1'b0;
      base_q  <= '0;
      k_q     <= '0;
      vvld_q  <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_IDLE: if (in_valid_i) begin
          k_q <= '0;
          if (in_bad) begin
            bad_q <= 1'b1;
          end
        end
        S_LD_WR: begin
          vvld_q[ld_v] <= 1'b1;
          if (k_q == 3'd5) begin
            k_q    <= '0;
            ecnt_q <= ecnt_q + EW'(1);
            base_q <= base_q + AW'(ARCS_PER_EDGE);
          end else begin
            k_q <= k_q + 3'd1;
          end
        end
        S_CLEAR: begin
          vvld_q <= '0;
          ecnt_q <= '0;
          bad_q  <= 1'b0;
          base_q <= '0;
        end
        default: k_q <= k_q;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    rv_q <= vl_raddr;
    rc_q <= cu_raddr;
    case (state_q)
      S_IDLE: begin
        ea_q    <= VW'(node_from_i);
        eb_q    <= VW'(node_to_i);
        elo_q   <= CAP_BITS'(lower_bound_i);
        eup_q   <= CAP_BITS'(upper_bound_i);
        elast_q <= last_edge_i;
      end
      S_RUN: code_q <= ST_BAD;
      S_BF_START: begin
        reached_q         <= '0;
        reached_q[SOURCE] <= 1'b1;
        head_q            <= '0;
        tail_q            <= HW'(1);
      end
      S_BF_POP: begin
        if (head_q != tail_q) begin
          head_q <= head_q + HW'(1);
        end
        e_q      <= '0;
        p_q      <= AW'(2);
        infeas_q <= 1'b0;
      end
      S_BF_LIST: begin
        a_q    <= vfirst;
        clvl_q <= lv_rdata;
      end
      S_BF_ARCW: begin
        if (bf_take) begin
          reached_q[ad_tgt] <= 1'b1;
          if (32'(tail_q) < NVERT) begin
            tail_q <= tail_q + HW'(1);
          end
        end
        a_q <= nx_rdata;
      end
      S_DF_INIT: cinit_q <= '0;
      S_DF_PATH: begin
        d_q   <= '0;
        u_q   <= SOURCE;
        lim_q <= FLOW_INF;
      end
      S_DF_NODE: i_q <= '0;
      S_DF_CUR: begin
        clvl_q <= lv_rdata;
        a_q    <= cstart;
      end
      S_DF_SCAN: if (a_q >= NARCS_N) begin
        cinit_q[u_q] <= 1'b1;
      end
      S_DF_SCANW: begin
        tgt_q  <= ad_tgt;
        room_q <= room_now;
        nxt_q  <= nx_rdata;
        if (!df_ok) begin
          a_q <= nx_rdata;
        end
      end
      S_DF_LVLW: if (lv_match) begin
        cinit_q[u_q] <= 1'b1;
        if (stack_room) begin
          d_q   <= d_q + SAW'(1);
          u_q   <= tgt_q;
          lim_q <= (room_q < lim_q) ? room_q : lim_q;
        end
      end else begin
        a_q <= nxt_q;
      end
      S_DF_RET: if (d_q != '0) begin
        d_q <= d_q - SAW'(1);
      end
      S_DF_RETW: begin
        u_q   <= wk_node;
        lim_q <= wk_lim;
      end
      S_DF_RETC: if (cstart >= NARCS_N) begin
        cinit_q[u_q] <= 1'b1;
      end
      S_DF_RETN: cinit_q[u_q] <= 1'b1;
      S_PU_W: pa_q <= wk_arc;
      S_PU_B: i_q <= i_q + SAW'(1);
      S_CK_W: begin
        if (ad_flow < cap_ext) begin
          infeas_q <= 1'b1;
        end
        e_q <= e_q + EW'(1);
        p_q <= p_q + AW'(ARCS_PER_EDGE);
      end
      S_CK_DONE: begin
        e_q    <= '0;
        p_q    <= '0;
        code_q <= infeas_q ? ST_NOCIRC : ST_OK;
      end
      S_OUT_B: f_q <= ad_flow;
      S_OUT_C: if (res_ready_i) begin
        e_q <= e_q + EW'(1);
        p_q <= p_q + AW'(ARCS_PER_EDGE);
      end
      default: f_q <= f_q;
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/flow_circulation_lower_bounds.sv
// ----------------------------------------------------------------------------
// flow_circulation_lower_bounds
// Feasible circulation with lower and upper edge bounds, solved by max flow.
// ----------------------------------------------------------------------------
// Edges arrive one word at a time on the slave stream; tlast marks the final
// edge of a graph and starts the solve. Each stored edge is fully loaded before
// the next ready: six residual arcs are appended, each in S_LD_RD then S_LD_WR,
// through the single write port of the arc memory. The solve after the last
// edge runs for a data-dependent time in the level pass, path search and
// augmentation, roughly proportional to the arcs scanned per phase times the
// number of phases.
// Results leave on the master stream: one status word (tuser) for an
// infeasible, bad or empty graph, else one word per edge in load order, tlast on
// the final one. An output register parts the two streams; a stalled receiver
// holds the sequencer at the pending word, nothing is dropped.
// Reset empties the graph and sets node_count to 62; the memories need no
// clearing pass. node_count is written through cfg_we_i / cfg_wdata_i; the user
// must write it only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module flow_circulation_lower_bounds #(
  parameter int unsigned MAX_NODES = fclb_pkg::DEF_MAX_NODES,
  parameter int unsigned MAX_EDGES = fclb_pkg::DEF_MAX_EDGES,
  parameter int unsigned CAP_BITS  = fclb_pkg::DEF_CAP_BITS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [5:0]  cfg_wdata_i,    // node_count
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [55:0] s_axis_tdata,   // node_from[5:0], node_to[11:6],
                                           // lower_bound[31:12], upper_bound[51:32]
  input  wire logic        s_axis_tlast,   // last_edge
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // edge_index[5:0], edge_flow[25:6]
  output logic [1:0]       m_axis_tuser,   // status[1:0]
  output logic             m_axis_tlast    // last
);
  import fclb_pkg::*;

  `include "assert_macros.svh"

  logic [NODE_W-1:0] node_count_q;
  res_t              eng_res;
  logic              res_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NODE_COUNT_RST;
    end else if (cfg_we_i) begin
      node_count_q <= cfg_wdata_i;
    end
  end

  fclb_engine #(
    .MAX_NODES(MAX_NODES),
    .MAX_EDGES(MAX_EDGES),
    .CAP_BITS (CAP_BITS)
  ) u_engine (
    .clk_i,
    .rst_ni,
    .node_count_i (node_count_q),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .node_from_i  (s_axis_tdata[5:0]),
    .node_to_i    (s_axis_tdata[11:6]),
    .lower_bound_i(s_axis_tdata[31:12]),
    .upper_bound_i(s_axis_tdata[51:32]),
    .last_edge_i  (s_axis_tlast),
    .res_o        (eng_res),
    .res_ready_i  (res_ready)
  );

  fclb_obuf u_obuf (
    .clk_i,
    .rst_ni,
    .res_i        (eng_res),
    .res_ready_o  (res_ready),
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .m_axis_tlast
  );

  `FCLB_NEVER(a_no_take_while_emit, s_axis_tready && eng_res.valid, "edge taken during emit")
  `FCLB_ASSERT(a_emit_held, eng_res.valid && !res_ready |=> eng_res.valid, "result word dropped")
  `FCLB_ASSERT(a_status_single, m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tlast && m_axis_tdata == 32'd0, "status word not final")

endmodule

`default_nettype wire

FILE: verif/flow_circulation_lower_bounds_tb.sv
// ----------------------------------------------------------------------------
// flow_circulation_lower_bounds_tb
// Self-checking bench for the circulation-with-lower-bounds solver.
// ----------------------------------------------------------------------------
// Edges stream in as words, and a behavioural Dinic solver in the bench
// predicts every result word. Directed runs cover bound extremes, bad edges,
// infeasible graphs and node_count extremes, including an overfull graph.
// Random runs are mostly valid circulations built from cycles, with some
// noise and bad edges mixed in. They run under four idling patterns on the
// sender and the receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module flow_circulation_lower_bounds_tb;
  import fclb_pkg::*;

  localparam int NV       = 64;
  localparam int NA       = 384;
  localparam int MAXE     = 64;
  localparam int SINK_V   = 63;
  localparam int NO_ARC   = 'h3FF;
  localparam longint INF  = 64'd2000000000;
  localparam int SETTLE   = 60;
  localparam int WD_LIMIT = 400000;

  typedef struct {
    status_e     st;
    logic [5:0]  idx;
    logic [19:0] flow;
    logic        lst;
  } flow_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [5:0]  cfg_wdata = '0;
  logic        s_valid = 1'b0;
  logic [55:0] s_data = '0;
  logic        s_last = 1'b0;
  logic        m_ready = 1'b0;
  logic        s_ready;
  logic        m_valid;
  logic [31:0] m_data;
  logic [1:0]  m_user;
  logic        m_last;

  flow_circulation_lower_bounds i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_ready),
    .s_axis_tdata (s_data),
    .s_axis_tlast (s_last),
    .m_axis_tvalid(m_valid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_data),
    .m_axis_tuser (m_user),
    .m_axis_tlast (m_last)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // solver image
  int     arc_to [NA];
  longint arc_cap[NA];
  longint arc_flw[NA];
  int     arc_nxt[NA];
  int     edge_lo[MAXE];
  int     v_first[NV];
  int     v_last [NV];
  int     v_lvl  [NV];
  bit     v_seen [NV];
  int     v_cur  [NV];
  int     bfs_q  [NV];
  int     path_arc[64];
  longint path_lim[64];
  int     n_edges;
  bit     bad_seen;
  int     node_cnt = 62;

  flow_word_t flow_words_q[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;
  int words_checked = 0;
  int edges_sent = 0;
  int runs_sent = 0;
  int quiet_cycles = 0;

  function automatic void graph_clear();
    for (int v = 0; v < NV; v++) begin
      v_first[v] = NO_ARC;
      v_last[v] = NO_ARC;
    end
    n_edges = 0;
    bad_seen = 0;
  endfunction

  function automatic void link_arc(int v, int a);
    arc_nxt[a] = NO_ARC;
    if (v_first[v] == NO_ARC) v_first[v] = a;
    else arc_nxt[v_last[v]] = a;
    v_last[v] = a;
  endfunction

  function automatic void add_arc_pair(int a, int u, int v, longint c);
    arc_to[a] = v; arc_cap[a] = c; arc_flw[a] = 0;
    link_arc(u, a);
    arc_to[a+1] = u; arc_cap[a+1] = 0; arc_flw[a+1] = 0;
    link_arc(v, a + 1);
  endfunction

  function automatic int nxt_of(int a);
    return (a < NA) ? arc_nxt[a] : NO_ARC;
  endfunction

  function automatic bit build_levels();
    int head, tail, cur, a, t;
    head = 0; tail = 0;
    for (int v = 0; v < NV; v++) v_seen[v] = 0;
    v_seen[0] = 1;
    v_lvl[0] = 0;
    bfs_q[tail++] = 0;
    while (head < tail) begin
      cur = bfs_q[head++];
      a = v_first[cur];
      while (a < NA) begin
        t = arc_to[a];
        if (!v_seen[t] && arc_flw[a] < arc_cap[a]) begin
          v_seen[t] = 1;
          v_lvl[t] = v_lvl[cur] + 1;
          if (tail < NV) bfs_q[tail++] = t;
        end
        a = nxt_of(a);
      end
    end
    return v_seen[SINK_V];
  endfunction

  function automatic int path_node(int d);
    return (d == 0) ? 0 : arc_to[path_arc[d-1]];
  endfunction

  function automatic void push_blocking_flow();
    int d, u, a, p, t;
    bit found, adv;
    longint lim, room, pushed;
    for (int v = 0; v < NV; v++) v_cur[v] = v_first[v];
    forever begin
      d = 0;
      found = 0;
      path_lim[0] = INF;
      forever begin
        u = path_node(d);
        lim = path_lim[d];
        adv = 0;
        if (lim != 0) begin
          if (u == SINK_V) begin
            found = 1;
            break;
          end
          a = v_cur[u];
          while (a < NA) begin
            t = arc_to[a];
            if (v_seen[t] && v_lvl[t] == v_lvl[u] + 1) break;
            a = nxt_of(a);
          end
          v_cur[u] = (a < NA) ? a : NO_ARC;
          if (a < NA && d + 1 < 64) begin
            room = arc_cap[a] - arc_flw[a];
            path_arc[d] = a;
            path_lim[d+1] = (lim < room) ? lim : room;
            d++;
            adv = 1;
          end
        end
        if (!adv) begin
          if (d == 0) break;
          d--;
          p = path_node(d);
          v_cur[p] = nxt_of(v_cur[p]);
        end
      end
      if (!found) break;
      pushed = path_lim[d];
      for (int i = 0; i < d; i++) begin
        arc_flw[path_arc[i]] += pushed;
        arc_flw[path_arc[i] ^ 1] -= pushed;
      end
    end
  endfunction

  function automatic void push_status(status_e st);
    flow_word_t w;
    w.st = st; w.idx = '0; w.flow = '0; w.lst = 1'b1;
    flow_words_q.push_back(w);
  endfunction

  function automatic void predict_edge(int src, int dst, int lo, int up, bit lst);
    int nmax, base;
    bit ok;
    longint f;
    flow_word_t w;
    nmax = (node_cnt > 62) ? 62 : node_cnt;
    if (lo > up || src == 0 || dst == 0 || src > nmax || dst > nmax || n_edges >= MAXE) begin
      bad_seen = 1;
    end else begin
      base = n_edges * 6;
      add_arc_pair(base, dst, src, longint'(up - lo));
      add_arc_pair(base + 2, 0, src, longint'(lo));
      add_arc_pair(base + 4, dst, SINK_V, longint'(lo));
      edge_lo[n_edges] = lo;
      n_edges++;
    end
    if (!lst) return;
    if (bad_seen) begin
      push_status(ST_BAD);
    end else begin
      ok = 1;
      while (build_levels()) push_blocking_flow();
      for (int e = 0; e < n_edges; e++)
        if (arc_flw[e*6+2] < arc_cap[e*6+2]) ok = 0;
      if (!ok) begin
        push_status(ST_NOCIRC);
      end else if (n_edges == 0) begin
        push_status(ST_OK);
      end else begin
        for (int e = 0; e < n_edges; e++) begin
          f = arc_flw[e*6] + edge_lo[e];
          w.st = ST_OK;
          w.idx = e[5:0];
          w.flow = (f < 0) ? 20'd0 : f[19:0];
          w.lst = (e + 1 == n_edges);
          flow_words_q.push_back(w);
        end
      end
    end
    graph_clear();
  endfunction

  // drive one edge word; valid stays high for a following word
  task automatic send_edge(int src, int dst, int lo, int up, bit lst);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data <= {4'b0, up[19:0], lo[19:0], dst[5:0], src[5:0]};
    s_last <= lst;
    do @(posedge clk_i); while (!s_ready);
    predict_edge(src[5:0], dst[5:0], lo[19:0], up[19:0], lst);
    edges_sent++;
    if (lst) runs_sent++;
  endtask

  task automatic drain();
    s_valid <= 1'b0;
    wait (flow_words_q.size() == 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_node_count(int n);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= n[5:0];
    @(posedge clk_i);
    cfg_we <= 1'b0;
    node_cnt = n & 63;
  endtask

  function automatic int eff_nodes();
    return (node_cnt > 62) ? 62 : node_cnt;
  endfunction

  function automatic int rand_bound();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 15);
      1: return $urandom_range(0, 1000);
      2: return $urandom_range(0, 1000000);
      default: return $urandom_range(0, 20'hFFFFF);
    endcase
  endfunction

  task automatic test_bound_extremes();
    send_edge(62, 1, 0, 20'hFFFFF, 0);
    send_edge(1, 62, 20'hFFFFF, 20'hFFFFF, 1);
    send_edge(1, 2, 5, 5, 1);
    send_edge(3, 4, 0, 0, 1);
    send_edge(5, 5, 7, 7, 1);
    send_edge(42, 21, 1000000, 1000000, 0);
    send_edge(21, 42, 0, 1000000, 1);
    send_edge(1, 2, 10, 9, 0);
    send_edge(2, 1, 3, 8, 1);
    send_edge(0, 2, 0, 4, 1);
    send_edge(3, 63, 0, 4, 1);
    send_edge(2, 3, 1, 6, 0);
    send_edge(3, 2, 2, 2, 1);
  endtask

  task automatic test_node_count_limits();
    write_node_count(1);
    send_edge(1, 1, 5, 9, 1);
    send_edge(1, 2, 0, 1, 1);
    write_node_count(0);
    send_edge(1, 1, 0, 0, 1);
    write_node_count(63);
    send_edge(62, 61, 4, 9, 0);
    send_edge(61, 62, 0, 6, 1);
    send_edge(63, 62, 0, 1, 1);
    write_node_count(62);
  endtask

  task automatic test_overfull_graph();
    for (int i = 0; i < 65; i++)
      send_edge((i % 62) + 1, ((i + 1) % 62) + 1, 0, i, i == 64);
    send_edge(7, 8, 1, 1, 0);
    send_edge(8, 7, 1, 1, 1);
  endtask

  // circulations made of random cycles, with noise and bad edges mixed in
  task automatic random_run(int n_req);
    int sent, len, c, nodes[4], nmax, k;
    nmax = eff_nodes();
    sent = 0;
    while (sent < n_req) begin
      k = $urandom_range(0, 99);
      if (k < 8) begin
        send_edge($urandom_range(0, 63), $urandom_range(0, 63), rand_bound(), rand_bound(),
                  sent + 1 >= n_req);
        sent++;
      end else if (k < 20) begin
        c = rand_bound();
        send_edge($urandom_range(1, nmax), $urandom_range(1, nmax), $urandom_range(0, c), c,
                  sent + 1 >= n_req);
        sent++;
      end else begin
        len = $urandom_range(1, 4);
        c = rand_bound();
        for (int i = 0; i < len; i++) nodes[i] = $urandom_range(1, nmax);
        for (int i = 0; i < len && sent < n_req; i++) begin
          send_edge(nodes[i], nodes[(i + 1) % len], $urandom_range(0, c),
                    (c + $urandom_range(0, 50)) & 20'hFFFFF, sent + 1 >= n_req);
          sent++;
        end
      end
    end
  endtask

  task automatic test_random_phase(int idle_pct, int stall_pct);
    int done;
    drain();
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    done = 0;
    while (done < 95) begin
      write_node_count($urandom_range(0, 7) == 0 ? 63 : $urandom_range(2, 62));
      for (int r = 0; r < 4; r++) begin
        random_run(($urandom_range(0, 9) == 0) ? $urandom_range(20, 48)
                                                : $urandom_range(1, 10));
        done = edges_sent - done > 0 ? done : done;
      end
      done = done + 1;
      if (edges_sent > 95 * (idle_pct + stall_pct + 1)) break;
    end
  endtask

  always @(posedge clk_i) begin
    flow_word_t w;
    if (rst_ni) begin
      if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WD_LIMIT) begin
        $display("%0t: watchdog expired, %0d words outstanding", $time, flow_words_q.size());
        $display("flow_circulation_lower_bounds_tb: errors");
        $finish;
      end
      if (m_valid && m_ready) begin
        words_checked++;
        if (flow_words_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected word: status %0d idx %0d flow %0d last %0b",
                   $time, m_user, m_data[5:0], m_data[25:6], m_last);
        end else begin
          w = flow_words_q.pop_front();
          if (m_user != w.st || m_data[5:0] != w.idx || m_data[25:6] != w.flow ||
              m_last != w.lst) begin
            errors++;
            $display("%0t: mismatch: expected status %0d idx %0d flow %0d last %0b, got %0d %0d %0d %0b",
                     $time, w.st, w.idx, w.flow, w.lst, m_user, m_data[5:0], m_data[25:6],
                     m_last);
          end
        end
      end
    end
    m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  initial begin
    graph_clear();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_bound_extremes();
    test_node_count_limits();
    test_overfull_graph();
    test_random_phase(0, 0);
    test_random_phase(81, 0);
    test_random_phase(0, 81);
    test_random_phase(8, 8);
    drain();
    $display("Covered %0d edge words in %0d graphs and %0d result words,", edges_sent,
             runs_sent, words_checked);
    $display("over node_count extremes, bad edges and four idling patterns.");
    if (errors == 0) $display("flow_circulation_lower_bounds_tb: clean");
    else $display("flow_circulation_lower_bounds_tb: errors");
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/fclb_pkg.sv
sv/fclb_ram.sv
sv/fclb_obuf.sv
sv/fclb_engine.sv
sv/flow_circulation_lower_bounds.sv
verif/flow_circulation_lower_bounds_tb.sv
